// ===== rtl/swp_pkg.sv =====
// Shared types, register map and draw codes of the scrolling waveform plotter.
`default_nettype none

package swp_pkg;

  localparam int DEF_WIDTH        = 256;
  localparam int DEF_HALF_HEIGHT  = 120;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_ORIGIN_X     = 0;
  localparam int DEF_ORIGIN_Y     = 0;

  localparam int NUM_LANES  = 4;
  localparam int CH_W       = 2;
  localparam int GRID_K_W   = 4;
  localparam int GRID_K_MAX = 10;
  localparam int CFG_AW     = 6;
  localparam int CFG_DW     = 64;

  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [2:0] REG_SCALE_0       = 3'd1;
  localparam logic [2:0] REG_SCALE_1       = 3'd2;
  localparam logic [2:0] REG_SCALE_2       = 3'd3;
  localparam logic [2:0] REG_SCALE_3       = 3'd4;
  localparam logic [2:0] REG_WINDOW_COLOR  = 3'd5;
  localparam logic [2:0] REG_BACK_COLOR    = 3'd6;
  localparam logic [2:0] REG_TRACE_COLORS  = 3'd7;

  localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd4;
  localparam logic [15:0] RST_SCALE         = 16'd100;
  localparam logic [15:0] RST_WINDOW_COLOR  = 16'hFFFF;
  localparam logic [15:0] RST_BACK_COLOR    = 16'h0000;
  localparam logic [63:0] RST_TRACE_COLORS  = 64'hFFE0_001F_07E0_F800;

  localparam logic [2:0] PH_ERASE    = 3'd0;
  localparam logic [2:0] PH_GRID_POS = 3'd1;
  localparam logic [2:0] PH_GRID_NEG = 3'd2;
  localparam logic [2:0] PH_MID      = 3'd3;
  localparam logic [2:0] PH_TRACE    = 3'd4;

  typedef struct packed {
    logic [2:0]       channel_count;
    logic [3:0][15:0] scale;
    logic [15:0]      window_color;
    logic [15:0]      back_color;
    logic [63:0]      trace_colors;
  } swp_cfg_t;

  typedef struct packed {
    logic                load_item;
    logic                div_start;
    logic                push_write;
    logic                rd_issue;
    logic                emit;
    logic [2:0]          kind;
    logic                last;
    logic [CH_W-1:0]     ch;
    logic [GRID_K_W-1:0] grid_k;
  } swp_cmd_t;

  typedef struct packed {
    logic mode;
    logic col_ok;
    logic col_grid;
    logic div_done;
    logic out_free;
  } swp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/scrolling_waveform_plotter_top.sv =====
// Top level of the multi-channel scrolling waveform plotter.
//
// Input words arrive on a valid/ready channel. A push word (mode 0) converts the
// sample of each active channel into a plot row and shifts it into that channel's
// history line. A render word (mode 1) redraws one column and produces a run of
// pixel words on the output valid/ready channel, the final one marked by last.
// The shared restoring divider serves the channels of a push in turn and resolves
// one quotient bit per cycle. A render first reads the history of each active
// channel, then produces one pixel word per cycle, up to 31 words, as long as the
// receiver takes them; a column above WIDTH - 2 produces no words. The next input
// word is accepted as soon as the last pixel word is loaded into the output
// register, even while that word still waits for the receiver. When the receiver
// stalls, the output register holds its word and the render sequence pauses; no
// word is lost or repeated. Reset restores the register defaults and empties every
// history line; entries never written read as row zero, tracked by a fill count
// per line, so no clearing pass is needed. The user writes configuration through
// the APB-style port only while idle; the block itself does not enforce this.
`default_nettype none

module scrolling_waveform_plotter_top import swp_pkg::*; #(
  parameter int WIDTH        = DEF_WIDTH,
  parameter int HALF_HEIGHT  = DEF_HALF_HEIGHT,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int ORIGIN_X     = DEF_ORIGIN_X,
  parameter int ORIGIN_Y     = DEF_ORIGIN_Y
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [CFG_AW-1:0]  paddr,
  input  wire logic [CFG_DW-1:0]  pwdata,
  output logic      [CFG_DW-1:0]  prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               mode_i,
  input  wire logic signed [15:0] sample_0_i,
  input  wire logic signed [15:0] sample_1_i,
  input  wire logic signed [15:0] sample_2_i,
  input  wire logic signed [15:0] sample_3_i,
  input  wire logic        [7:0]  column_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [9:0]  pixel_x_o,
  output logic             [8:0]  pixel_y_o,
  output logic             [15:0] pixel_color_o,
  output logic                    last_o
);

  swp_cfg_t cfg;
  swp_cmd_t cmd;
  swp_sts_t sts;

  swp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swp_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .channel_count_i (cfg.channel_count),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  swp_datapath #(
    .WIDTH        (WIDTH),
    .HALF_HEIGHT  (HALF_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .ORIGIN_X     (ORIGIN_X),
    .ORIGIN_Y     (ORIGIN_Y)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .sample_0_i    (sample_0_i),
    .sample_1_i    (sample_1_i),
    .sample_2_i    (sample_2_i),
    .sample_3_i    (sample_3_i),
    .column_i      (column_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/swp_regs.sv =====
// APB-style configuration register file of the plotter.
`default_nettype none

module swp_regs import swp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output swp_cfg_t               cfg_o
);

  swp_cfg_t   cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[CFG_AW-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_CHANNEL_COUNT: cfg_d.channel_count = pwdata[2:0];
        REG_SCALE_0:       cfg_d.scale[0] = pwdata[15:0];
        REG_SCALE_1:       cfg_d.scale[1] = pwdata[15:0];
        REG_SCALE_2:       cfg_d.scale[2] = pwdata[15:0];
        REG_SCALE_3:       cfg_d.scale[3] = pwdata[15:0];
        REG_WINDOW_COLOR:  cfg_d.window_color = pwdata[15:0];
        REG_BACK_COLOR:    cfg_d.back_color = pwdata[15:0];
        REG_TRACE_COLORS:  cfg_d.trace_colors = pwdata;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHANNEL_COUNT: prdata = CFG_DW'(cfg_q.channel_count);
      REG_SCALE_0:       prdata = CFG_DW'(cfg_q.scale[0]);
      REG_SCALE_1:       prdata = CFG_DW'(cfg_q.scale[1]);
      REG_SCALE_2:       prdata = CFG_DW'(cfg_q.scale[2]);
      REG_SCALE_3:       prdata = CFG_DW'(cfg_q.scale[3]);
      REG_WINDOW_COLOR:  prdata = CFG_DW'(cfg_q.window_color);
      REG_BACK_COLOR:    prdata = CFG_DW'(cfg_q.back_color);
      REG_TRACE_COLORS:  prdata = cfg_q.trace_colors;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= RST_CHANNEL_COUNT;
      cfg_q.scale         <= {4{RST_SCALE}};
      cfg_q.window_color  <= RST_WINDOW_COLOR;
      cfg_q.back_color    <= RST_BACK_COLOR;
      cfg_q.trace_colors  <= RST_TRACE_COLORS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swp_ctrl.sv =====
// Sequencing state machine for pushes and column renders.
`default_nettype none

module swp_ctrl import swp_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] channel_count_i,
  input  wire swp_sts_t   sts_i,
  output swp_cmd_t        cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_RWAIT  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [CH_W-1:0]     ch_q, ch_d;
  logic [2:0]          phase_q, phase_d;
  logic [GRID_K_W-1:0] k_q, k_d;
  logic [2:0]          nch;
  logic                last_ch;

  assign nch = (channel_count_i > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : channel_count_i;
  assign last_ch = ({1'b0, ch_q} == (nch - 3'd1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    ch_d         = ch_q;
    phase_d      = phase_q;
    k_d          = k_q;
    cmd_o        = '0;
    cmd_o.ch     = ch_q;
    cmd_o.kind   = phase_q;
    cmd_o.grid_k = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        ch_d = '0;
        k_d  = '0;
        if (!sts_i.mode) begin
          state_d = (nch == 3'd0) ? S_IDLE : S_DSTART;
        end else if (!sts_i.col_ok) begin
          state_d = S_IDLE;
        end else if (nch == 3'd0) begin
          phase_d = sts_i.col_grid ? PH_GRID_POS : PH_MID;
          state_d = S_EMIT;
        end else begin
          state_d = S_READ;
        end
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.push_write = 1'b1;
          if (last_ch) begin
            state_d = S_IDLE;
          end else begin
            ch_d = ch_q + 1'b1;
            state_d = S_DSTART;
          end
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        if (last_ch) begin
          ch_d = '0;
          state_d = S_RWAIT;
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      S_RWAIT: begin
        phase_d = PH_ERASE;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          case (phase_q)
            PH_ERASE: begin
              if (last_ch) begin
                ch_d = '0;
                phase_d = sts_i.col_grid ? PH_GRID_POS : PH_MID;
              end else begin
                ch_d = ch_q + 1'b1;
              end
            end
            PH_GRID_POS: begin
              phase_d = PH_GRID_NEG;
            end
            PH_GRID_NEG: begin
              if (k_q == GRID_K_W'(GRID_K_MAX)) begin
                phase_d = PH_MID;
              end else begin
                k_d = k_q + 1'b1;
                phase_d = PH_GRID_POS;
              end
            end
            PH_MID: begin
              if (nch == 3'd0) begin
                cmd_o.last = 1'b1;
                state_d = S_IDLE;
              end else begin
                ch_d = '0;
                phase_d = PH_TRACE;
              end
            end
            PH_TRACE: begin
              if (last_ch) begin
                cmd_o.last = 1'b1;
                state_d = S_IDLE;
              end else begin
                ch_d = ch_q + 1'b1;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= '0;
      phase_q <= PH_ERASE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      phase_q <= phase_d;
      k_q     <= k_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swp_datapath.sv =====
// Datapath: item latch, serial divider, history memory and pixel output register.
`default_nettype none

module swp_datapath import swp_pkg::*; #(
  parameter int WIDTH        = DEF_WIDTH,
  parameter int HALF_HEIGHT  = DEF_HALF_HEIGHT,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int ORIGIN_X     = DEF_ORIGIN_X,
  parameter int ORIGIN_Y     = DEF_ORIGIN_Y
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire swp_cfg_t           cfg_i,
  input  wire swp_cmd_t           cmd_i,
  output swp_sts_t                sts_o,
  input  wire logic               mode_i,
  input  wire logic signed [15:0] sample_0_i,
  input  wire logic signed [15:0] sample_1_i,
  input  wire logic signed [15:0] sample_2_i,
  input  wire logic signed [15:0] sample_3_i,
  input  wire logic        [7:0]  column_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic             [9:0]  pixel_x_o,
  output logic             [8:0]  pixel_y_o,
  output logic             [15:0] pixel_color_o,
  output logic                    last_o
);

  localparam int PW        = $clog2(WIDTH);
  localparam int FW        = $clog2(WIDTH + 1);
  localparam int ROW_W     = $clog2(2 * HALF_HEIGHT + 1);
  localparam int MEM_DEPTH = MAX_CHANNELS * WIDTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int SUM_W     = ((PW > 8) ? PW : 8) + 2;
  localparam int GRID_STEP = HALF_HEIGHT / 10;
  localparam int RAIL      = 2 * HALF_HEIGHT;
  localparam int POS_W     = 12;
  localparam int NUM_W     = 18;
  localparam int DIV_BITS  = 17;
  localparam int CNT_W     = $clog2(DIV_BITS + 1);

  function automatic logic [3:0] mod10(input logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  quo;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd205;
    quo  = 8'(prod >> 11);
    rem  = v - 8'(quo * 8'd10);
    return rem[3:0];
  endfunction

  // Latched item.
  logic                     mode_q;
  logic signed [15:0]       sample_q [NUM_LANES];
  logic        [7:0]        col_q;

  // History line pointers and fill counts.
  logic [PW-1:0]            ptr_q  [NUM_LANES];
  logic [FW-1:0]            fill_q [NUM_LANES];
  logic [ROW_W-1:0]         hist_mem [MEM_DEPTH];
  logic [ROW_W-1:0]         rd_data_q;
  logic                     rd_pend_q, rd_ok_q;
  logic [CH_W-1:0]          rd_ch_q;
  logic [ROW_W-1:0]         rows_q [NUM_LANES];

  // Divider.
  logic [DIV_BITS-1:0]      div_q_q, div_rem_q, div_den_q;
  logic [CNT_W-1:0]         div_cnt_q;
  logic                     div_busy_q, div_neg_q;

  // Output word.
  logic                     out_valid_q;
  logic [9:0]               px_q;
  logic [8:0]               py_q;
  logic [15:0]              pc_q;
  logic                     pl_q;

  logic [15:0]              s_eff;
  logic [NUM_W-1:0]         num;
  logic [NUM_W-1:0]         num_neg;
  logic [DIV_BITS:0]        rem_sh;
  logic                     rem_ge;
  logic [DIV_BITS:0]        rem_sub;
  logic                     q_big;
  logic [DIV_BITS-1:0]      row_wide;
  logic [ROW_W-1:0]         new_row;
  logic [AW-1:0]            ch_base;
  logic [SUM_W-1:0]         rd_sum, rd_phys;
  logic                     rd_hit;
  logic [ROW_W-1:0]         sel_row;
  logic                     rail;
  logic [15:0]              trace_col;
  logic [POS_W-1:0]         gval, x_pos, y_pos;
  logic [15:0]              color;

  assign sts_o.mode     = mode_q;
  assign sts_o.col_ok   = (SUM_W'(col_q) <= SUM_W'(WIDTH - 2));
  assign sts_o.col_grid = (mod10(col_q) < 4'd3);
  assign sts_o.div_done = div_busy_q && (div_cnt_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q      <= mode_i;
      sample_q[0] <= sample_0_i;
      sample_q[1] <= sample_1_i;
      sample_q[2] <= sample_2_i;
      sample_q[3] <= sample_3_i;
      col_q       <= column_i;
    end
  end

  // The rounded quotient is formed as (2*d + s) / (2*s), truncated toward zero.
  assign s_eff   = (cfg_i.scale[cmd_i.ch] == 16'd0) ? 16'd1 : cfg_i.scale[cmd_i.ch];
  assign num     = {sample_q[cmd_i.ch][15], sample_q[cmd_i.ch], 1'b0} + NUM_W'(s_eff);
  assign num_neg = ~num + NUM_W'(1);
  assign rem_sh  = {div_rem_q, div_q_q[DIV_BITS-1]};
  assign rem_ge  = (rem_sh >= {1'b0, div_den_q});
  assign rem_sub = rem_sh - {1'b0, div_den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_q_q   <= num[NUM_W-1] ? num_neg[DIV_BITS-1:0] : num[DIV_BITS-1:0];
      div_neg_q <= num[NUM_W-1];
      div_den_q <= {s_eff, 1'b0};
      div_rem_q <= '0;
    end else if (div_busy_q && (div_cnt_q != '0)) begin
      div_rem_q <= rem_ge ? rem_sub[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
      div_q_q   <= {div_q_q[DIV_BITS-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= CNT_W'(DIV_BITS);
    end else if (cmd_i.push_write) begin
      div_busy_q <= 1'b0;
    end else if (div_busy_q && (div_cnt_q != '0)) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  // Row is HALF_HEIGHT minus the signed quotient, clamped to the plot rails.
  assign q_big    = (div_q_q > DIV_BITS'(HALF_HEIGHT));
  assign row_wide = div_neg_q ? (q_big ? DIV_BITS'(RAIL) : DIV_BITS'(HALF_HEIGHT) + div_q_q)
                              : (q_big ? '0 : DIV_BITS'(HALF_HEIGHT) - div_q_q);
  assign new_row  = row_wide[ROW_W-1:0];

  assign ch_base = AW'(AW'(cmd_i.ch) * AW'(WIDTH));
  assign rd_sum  = SUM_W'(ptr_q[cmd_i.ch]) + SUM_W'(col_q);
  assign rd_phys = (rd_sum >= SUM_W'(WIDTH)) ? (rd_sum - SUM_W'(WIDTH)) : rd_sum;
  assign rd_hit  = ((SUM_W'(col_q) + SUM_W'(fill_q[cmd_i.ch])) >= SUM_W'(WIDTH));

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_write) begin
      hist_mem[ch_base + AW'(ptr_q[cmd_i.ch])] <= new_row;
    end
    rd_data_q <= hist_mem[ch_base + AW'(rd_phys[PW-1:0])];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        ptr_q[i]  <= '0;
        fill_q[i] <= '0;
      end
    end else if (cmd_i.push_write) begin
      ptr_q[cmd_i.ch] <= (ptr_q[cmd_i.ch] == PW'(WIDTH - 1)) ? '0 : ptr_q[cmd_i.ch] + 1'b1;
      if (fill_q[cmd_i.ch] != FW'(WIDTH)) begin
        fill_q[cmd_i.ch] <= fill_q[cmd_i.ch] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_ok_q <= rd_hit;
      rd_ch_q <= cmd_i.ch;
    end
    if (rd_pend_q) begin
      rows_q[rd_ch_q] <= rd_ok_q ? rd_data_q : '0;
    end
  end

  // Pixel word for the current draw step.
  assign sel_row   = rows_q[cmd_i.ch];
  assign rail      = (sel_row == '0) || (sel_row == ROW_W'(RAIL));
  assign trace_col = cfg_i.trace_colors[{cmd_i.ch, 4'd0} +: 16];
  assign gval      = POS_W'(cmd_i.grid_k) * POS_W'(GRID_STEP);
  assign x_pos     = POS_W'(ORIGIN_X) + POS_W'(col_q) +
                     ((cmd_i.kind == PH_ERASE) ? POS_W'(1) : POS_W'(0));

  always_comb begin
    case (cmd_i.kind)
      PH_ERASE: begin
        y_pos = POS_W'(ORIGIN_Y) + POS_W'(sel_row);
        color = rail ? cfg_i.window_color : cfg_i.back_color;
      end
      PH_GRID_POS: begin
        y_pos = POS_W'(ORIGIN_Y) + POS_W'(HALF_HEIGHT) + gval;
        color = cfg_i.window_color;
      end
      PH_GRID_NEG: begin
        y_pos = POS_W'(ORIGIN_Y) + POS_W'(HALF_HEIGHT) - gval;
        color = cfg_i.window_color;
      end
      PH_TRACE: begin
        y_pos = POS_W'(ORIGIN_Y) + POS_W'(sel_row);
        color = rail ? cfg_i.window_color : trace_col;
      end
      default: begin
        y_pos = POS_W'(ORIGIN_Y) + POS_W'(HALF_HEIGHT);
        color = cfg_i.window_color;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      px_q <= x_pos[9:0];
      py_q <= y_pos[8:0];
      pc_q <= color;
      pl_q <= cmd_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pc_q;
  assign last_o        = pl_q;

endmodule

`default_nettype wire
